[src/linear_interp_resampler_macros.svh]
// Assertion helpers shared by the resampler RTL.
// Each macro expands to one labelled concurrent assertion on the rising clock edge,
// disabled while reset is high.
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// Same-cycle implication
`define LIR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define LIR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lir_pkg.sv]
`timescale 1ns / 1ps
package lir_pkg;

  // Field and state widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned EP_W     = 20;
  localparam int unsigned CNT_W    = 24;
  localparam int unsigned OFF_W    = 21;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned P_W      = 15;

  // Divider widths: dividend magnitude and quotient
  localparam int unsigned DIV_NW   = 32;
  localparam int unsigned DIV_QW   = 17;

  // Last position index handled per sample request
  localparam logic [POS_W-1:0] POS_LAST = 4'd7;

  // Quotient bound for a rounded sample magnitude
  localparam logic [DIV_QW-1:0] QUO_MAX = 17'd32768;

  // Configuration register indexes
  localparam logic CFG_EXPORT_PERIOD = 1'b0;
  localparam logic CFG_OUTPUT_COUNT  = 1'b1;

  // Input kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [EP_W-1:0]  EXPORT_PERIOD_RST = 20'd22676;
  localparam logic [CNT_W-1:0] OUTPUT_COUNT_RST  = 24'd44100;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DISPATCH = 7'b0000010,
    ST_LOOP     = 7'b0000100,
    ST_SUM      = 7'b0001000,
    ST_LOAD     = 7'b0010000,
    ST_DIV      = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } lir_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_in;
    logic load_hold;
    logic load_first;
    logic skip;
    logic mul;
    logic sum;
    logic div_start;
    logic fix;
    logic emit;
    logic finish;
  } lir_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic kind_flush;
    logic seen_first;
    logic below_count;
    logic in_window;
    logic div_done;
    logic slot_free;
    logic res_interp;
  } lir_sts_t;

endpackage

[src/lir_div.sv]
`timescale 1ns / 1ps
`include "linear_interp_resampler_macros.svh"
module lir_div #(
  parameter int unsigned DIVISOR = 40228
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lir_pkg::DIV_NW-1:0] dividend,
  output logic [lir_pkg::DIV_QW-1:0] quotient,
  output logic                       done
);
  import lir_pkg::*;

  // Reciprocal rounded up, scaled so that the truncated product is the exact
  // quotient for every dividend below 2^31
  localparam int unsigned     SHIFT = 31 + $clog2(DIVISOR);
  localparam longint unsigned SCALE = 64'd1 << SHIFT;
  localparam logic [32:0]     RECIP = 33'((SCALE + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [DIV_NW-1:0] dvd;
  logic [48:0]       prod_lo;
  logic [48:0]       prod_hi;
  logic [63:0]       acc;
  logic              step1;
  logic              step2;

  // Control: advance the request through the three stages, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      step1 <= 1'b0;
      step2 <= 1'b0;
      done  <= 1'b0;
    end else begin
      step1 <= start;
      step2 <= step1;
      done  <= step2;
    end
  end

  // Datapath: hold the dividend, multiply both halves, then add the partial products
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (step1) begin
      prod_lo <= dvd[15:0] * RECIP;
      prod_hi <= dvd[DIV_NW-1:16] * RECIP;
    end
    if (step2) begin
      acc <= 64'({prod_hi, 16'h0000}) + 64'(prod_lo);
    end
  end

  assign quotient = acc[SHIFT +: DIV_QW];

  `LIR_ASSERT_NXT(a_div_start_quiet, clk, rst, start, !done, "divider done right after start")
  `LIR_ASSERT_NXT(a_div_done_pulse, clk, rst, done, !done, "divider done held for two cycles")
  `LIR_ASSERT_IMP(a_div_quo_range, clk, rst, done, quotient <= QUO_MAX, "quotient too large")

endmodule

[src/lir_dp.sv]
`timescale 1ns / 1ps
`include "linear_interp_resampler_macros.svh"
module lir_dp #(
  parameter int unsigned SAMPLE_PERIOD_NS = 20114
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lir_pkg::CFG_W-1:0]    cfg_data,
  input  logic [lir_pkg::SAMPLE_W-1:0] s_tdata,
  input  logic                         s_tuser,
  output logic [lir_pkg::SAMPLE_W-1:0] m_tdata,
  output logic                         m_tuser,
  output logic                         m_tlast,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  lir_pkg::lir_cmd_t            cmd,
  output lir_pkg::lir_sts_t            sts
);
  import lir_pkg::*;

  localparam logic [OFF_W-1:0]           D_OFF = OFF_W'(SAMPLE_PERIOD_NS);
  localparam logic signed [SAMPLE_W-1:0] D_S   = SAMPLE_W'(SAMPLE_PERIOD_NS);
  localparam logic signed [34:0]         D_N   = 35'(SAMPLE_PERIOD_NS);

  // Configuration
  logic [EP_W-1:0]  export_period;
  logic [CNT_W-1:0] output_count;

  // Stream state
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic                       cur_kind;
  logic [OFF_W-1:0]           next_offset;
  logic                       seen_first;
  logic [CNT_W-1:0]           emitted;
  logic [POS_W-1:0]           pos;

  // Arithmetic pipeline
  logic signed [31:0]          prod_a;
  logic signed [32:0]          prod_d;
  logic signed [34:0]          num2;
  logic                        neg;
  logic signed [SAMPLE_W:0]    diff;
  logic signed [SAMPLE_W-1:0]  p_s;
  logic [DIV_NW-1:0]           mag;
  logic [34:0]                 num2_abs;
  logic [DIV_QW-1:0]           quotient;
  logic                        div_done;

  // Result staging and output register
  logic [SAMPLE_W-1:0] res_value;
  logic                res_held;
  logic                res_interp;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_held;
  logic                out_last;
  logic                out_valid;

  logic [OFF_W-1:0] off_step;
  logic [CNT_W:0]   emitted_inc;
  logic [CNT_W:0]   count_ext;
  logic             count_hit;
  logic             more;
  logic             slot_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      export_period <= EXPORT_PERIOD_RST;
      output_count  <= OUTPUT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPORT_PERIOD: export_period <= cfg_data[EP_W-1:0];
        CFG_OUTPUT_COUNT:  output_count  <= cfg_data[CNT_W-1:0];
        default:           export_period <= export_period;
      endcase
    end
  end

  assign off_step    = next_offset + OFF_W'(export_period);
  assign emitted_inc = {1'b0, emitted} + 1'b1;
  assign count_ext   = {1'b0, output_count};
  assign count_hit   = (emitted_inc >= count_ext);
  // Another output follows within this request
  assign more        = (pos < POS_LAST) && (off_step <= D_OFF) && !count_hit;
  assign slot_free   = !out_valid || m_tready;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      cur_sample <= s_tdata;
      cur_kind   <= s_tuser;
    end
  end

  // Stream state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      next_offset <= '0;
      seen_first  <= 1'b0;
      emitted     <= '0;
      pos         <= '0;
    end else begin
      if (cmd.take_in) begin
        pos <= '0;
      end
      if (cmd.load_first) begin
        seen_first  <= 1'b1;
        prev_sample <= cur_sample;
        next_offset <= OFF_W'(export_period);
      end
      if (cmd.skip) begin
        next_offset <= off_step;
        pos         <= pos + 1'b1;
      end
      if (cmd.emit) begin
        emitted <= emitted + 1'b1;
        if (res_interp) begin
          next_offset <= off_step;
          pos         <= pos + 1'b1;
        end
      end
      // Close the interval: carry the overshoot to the new sample
      if (cmd.finish) begin
        next_offset <= (next_offset > D_OFF) ? (next_offset - D_OFF) : '0;
        prev_sample <= cur_sample;
      end
    end
  end

  // Products: D*a and p*(b-a)
  assign diff = $signed({cur_sample[SAMPLE_W-1], cur_sample})
              - $signed({prev_sample[SAMPLE_W-1], prev_sample});
  assign p_s  = $signed({1'b0, next_offset[P_W-1:0]});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_a <= D_S * prev_sample;
      prod_d <= p_s * diff;
    end
  end

  // Doubled numerator plus D, for round half up before truncation
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      num2 <= ((35'(prod_a) + 35'(prod_d)) <<< 1) + D_N;
    end
  end

  // Split sign and magnitude for the unsigned divider
  assign num2_abs = num2[34] ? 35'(-num2) : 35'(num2);
  assign mag      = num2_abs[DIV_NW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= num2[34];
    end
  end

  lir_div #(
    .DIVISOR(2 * SAMPLE_PERIOD_NS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mag),
    .quotient (quotient),
    .done     (div_done)
  );

  // Stage the next result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_interp <= 1'b0;
    end else if (cmd.load_hold) begin
      res_interp <= 1'b0;
    end else if (cmd.load_first) begin
      res_interp <= 1'b0;
    end else if (cmd.fix) begin
      res_interp <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_hold) begin
      res_value <= prev_sample;
      res_held  <= 1'b1;
    end else if (cmd.load_first) begin
      res_value <= cur_sample;
      res_held  <= 1'b0;
    end else if (cmd.fix) begin
      res_value <= neg ? SAMPLE_W'(-quotient) : quotient[SAMPLE_W-1:0];
      res_held  <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample <= res_value;
      out_held   <= res_held;
      out_last   <= res_interp ? !more : 1'b1;
    end
  end

  assign m_tdata  = out_sample;
  assign m_tuser  = out_held;
  assign m_tlast  = out_last;
  assign m_tvalid = out_valid;

  assign sts.kind_flush  = (cur_kind == KIND_FLUSH);
  assign sts.seen_first  = seen_first;
  assign sts.below_count = (emitted < output_count);
  assign sts.in_window   = !pos[POS_W-1] && (next_offset <= D_OFF);
  assign sts.div_done    = div_done;
  assign sts.slot_free   = slot_free;
  assign sts.res_interp  = res_interp;

  `LIR_ASSERT_IMP(a_emit_slot, clk, rst, cmd.emit, slot_free, "result loaded over a waiting one")
  `LIR_ASSERT_IMP(a_mul_window, clk, rst, cmd.mul, sts.in_window, "multiply outside the interval")
  `LIR_ASSERT_NXT(a_last_at_count, clk, rst, cmd.emit && count_hit, m_tlast, "tlast missing")

endmodule

[src/lir_ctrl.sv]
`timescale 1ns / 1ps
module lir_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  lir_pkg::lir_sts_t sts,
  output lir_pkg::lir_cmd_t cmd
);
  import lir_pkg::*;

  lir_state_t state;
  lir_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one request through dispatch, the position loop and the output slot
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.take_in = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.kind_flush) begin
          if (sts.seen_first && sts.below_count) begin
            cmd.load_hold = 1'b1;
            state_next    = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end else if (!sts.seen_first) begin
          cmd.load_first = 1'b1;
          state_next     = sts.below_count ? ST_EMIT : ST_IDLE;
        end else begin
          state_next = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (sts.in_window) begin
          if (sts.below_count) begin
            cmd.mul    = 1'b1;
            state_next = ST_SUM;
          end else begin
            // Count reached: consume the position silently
            cmd.skip = 1'b1;
          end
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) begin
          cmd.fix    = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.res_interp ? ST_LOOP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign s_tready = (state == ST_IDLE);

endmodule

[src/linear_interp_resampler.sv]
`timescale 1ns / 1ps
// Linear interpolation resampler.
// s_* channel: one request per input item; s_tuser is the kind (0 sample, 1 flush),
// s_tdata the signed 16-bit sample. m_* channel: s_tdata-like result with tuser =
// held flag (flush repeat) and tlast on the final result of each request.
// cfg_we/cfg_index/cfg_data write export_period (index 0) or output_count (index 1);
// write only while the block is idle.
// A flush or the first sample passes through the dispatch and emit states before its
// result enters the output register. Each interpolated output passes through multiply,
// sum, load, the reciprocal multiply for the division by twice the input period, and
// the load of the output register.
// A request that falls past the output count still walks its positions, one a cycle.
// One request is in work at a time; the next is accepted in the cycle after the last
// result enters the output register or, after an interpolated one, once the position
// loop has closed the interval, so a waiting result does not block acceptance.
// Reset clears the stream state and reloads the configuration defaults.
// A stalled receiver holds the output register; work pauses until the slot frees.
module linear_interp_resampler #(
  parameter int unsigned SAMPLE_PERIOD_NS = 20114
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [lir_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [lir_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample
  input  logic                         s_tuser,   // [0] kind
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lir_pkg::SAMPLE_W-1:0] m_tdata,   // [15:0] out_sample
  output logic                         m_tuser,   // [0] held
  output logic                         m_tlast
);
  import lir_pkg::*;

  lir_cmd_t cmd;
  lir_sts_t sts;

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lir_dp #(
    .SAMPLE_PERIOD_NS(SAMPLE_PERIOD_NS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import lir_pkg::*;

  localparam int unsigned IN_PERIOD_NS   = 20114;
  localparam int unsigned MAX_POSITIONS  = 8;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned ITEMS_PER_SET  = 66;

  // Input request and output result as the ports carry them
  typedef struct packed {
    logic        kind;
    logic [15:0] smp;
  } req_t;

  typedef struct packed {
    logic [15:0] smp;
    logic        held;
    logic        last;
  } res_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;   // [15:0] sample
  logic                s_tuser = 1'b0; // [0] kind
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;        // [15:0] out_sample
  logic                m_tuser;        // [0] held
  logic                m_tlast;

  linear_interp_resampler #(
    .SAMPLE_PERIOD_NS(IN_PERIOD_NS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  req_t pending_reqs[$];
  res_t expected_samples[$];

  // Mirror of the resampler configuration and stream state
  logic [EP_W-1:0]            period_ns = EXPORT_PERIOD_RST;
  logic [CNT_W-1:0]           out_limit = OUTPUT_COUNT_RST;
  logic signed [SAMPLE_W-1:0] last_smp = '0;
  logic [OFF_W-1:0]           offset_ns = '0;
  logic                       started = 1'b0;
  logic [CNT_W-1:0]           produced = '0;

  int unsigned src_idle = 13;
  int unsigned snk_idle = 62;
  int unsigned reqs_offered = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned reqs_taken = 0;
  int unsigned flush_reqs = 0;
  int unsigned clipped_reqs = 0;
  int unsigned withheld = 0;
  int unsigned results_checked = 0;
  int unsigned held_results = 0;
  res_t        want;

  // Rounded linear blend at offset p ns after sample a, truncated toward zero
  function automatic logic [15:0] blend(logic signed [15:0] a, logic signed [15:0] b,
                                        int unsigned p);
    longint d;
    longint pp;
    longint num;
    d   = IN_PERIOD_NS;
    pp  = p;
    num = (d - pp) * longint'(a) + pp * longint'(b);
    return 16'((2 * num + d) / (2 * d));
  endfunction

  // Advance the mirror by one request and queue the samples it should produce
  function automatic void resample(logic kind, logic signed [15:0] smp);
    res_t        batch[$];
    int unsigned off;
    int unsigned pos;
    if (kind == KIND_FLUSH) begin
      flush_reqs++;
      if (started && produced < out_limit) begin
        batch.push_back({last_smp, 1'b1, 1'b0});
        produced++;
      end else if (started) begin
        withheld++;
      end
    end else if (!started) begin
      started   = 1'b1;
      last_smp  = smp;
      offset_ns = OFF_W'(period_ns);
      if (produced < out_limit) begin
        batch.push_back({smp, 1'b0, 1'b0});
        produced++;
      end else begin
        withheld++;
      end
    end else begin
      off = offset_ns;
      pos = 0;
      while (pos < MAX_POSITIONS && off <= IN_PERIOD_NS) begin
        if (produced < out_limit) begin
          batch.push_back({blend(last_smp, smp, off), 1'b0, 1'b0});
          produced++;
        end else begin
          withheld++;
        end
        off += period_ns;
        pos++;
      end
      // drop positions beyond the eighth and restart at the new sample
      if (off <= IN_PERIOD_NS) clipped_reqs++;
      if (off > IN_PERIOD_NS) off -= IN_PERIOD_NS;
      else off = 0;
      offset_ns = OFF_W'(off);
      last_smp  = smp;
    end
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_samples.push_back(batch[i]);
  endfunction

  // Present the next pending request; hold it until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || reqs_taken == reqs_offered) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle) begin
        s_tvalid <= 1'b1;
        s_tuser  <= pending_reqs[0].kind;
        s_tdata  <= pending_reqs[0].smp;
        reqs_offered++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Record each accepted request and predict its samples
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      resample(s_tuser, s_tdata);
      void'(pending_reqs.pop_front());
      reqs_taken++;
    end
  end

  // Stall the receiver at random
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= snk_idle);
  end

  // Check each result against the oldest prediction; watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: sample %h held %b last %b",
                     m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          results_checked++;
          if (m_tuser) held_results++;
          if (m_tdata !== want.smp || m_tuser !== want.held || m_tlast !== want.last) begin
            if (errors < 10)
              $display("mismatch at result %0d: expected %h/%b/%b got %h/%b/%b",
                       results_checked, want.smp, want.held, want.last,
                       m_tdata, m_tuser, m_tlast);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", stall_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic push_req(logic kind, logic [15:0] smp);
    pending_reqs.push_back({kind, smp});
  endtask

  // Wait for every request and result to drain, then let the block go idle
  task automatic settle();
    while (pending_reqs.size() != 0 || s_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_EXPORT_PERIOD) period_ns = val[EP_W-1:0];
    else out_limit = val[CNT_W-1:0];
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed: flush with no sample yet, first sample passed through, extremes
    push_req(KIND_FLUSH, 16'h1234);
    push_req(KIND_SAMPLE, 16'h8000);
    push_req(KIND_SAMPLE, 16'h7fff);
    push_req(KIND_SAMPLE, 16'h8000);
    push_req(KIND_FLUSH, 16'h5555);
    push_req(KIND_FLUSH, 16'haaaa);
    push_req(KIND_SAMPLE, 16'hffff);
    push_req(KIND_SAMPLE, 16'h0001);
    settle();

    // Short output period: several outputs per sample
    write_cfg(CFG_EXPORT_PERIOD, 24'd4096);
    push_req(KIND_SAMPLE, 16'h7fff);
    push_req(KIND_SAMPLE, 16'h8000);
    push_req(KIND_SAMPLE, 16'h0000);
    push_req(KIND_SAMPLE, 16'h7fff);
    settle();

    // Period short enough that positions beyond eight are dropped
    write_cfg(CFG_EXPORT_PERIOD, 24'd1000);
    push_req(KIND_SAMPLE, 16'h8000);
    push_req(KIND_SAMPLE, 16'h7fff);
    push_req(KIND_SAMPLE, 16'h1234);
    settle();

    // Output count reached part-way through a sample, then a zero count
    write_cfg(CFG_EXPORT_PERIOD, 24'd4096);
    write_cfg(CFG_OUTPUT_COUNT, 24'(produced + 2));
    push_req(KIND_SAMPLE, 16'h7fff);
    push_req(KIND_SAMPLE, 16'h8000);
    push_req(KIND_FLUSH, 16'h0000);
    settle();
    write_cfg(CFG_OUTPUT_COUNT, 24'd0);
    push_req(KIND_SAMPLE, 16'h4321);
    push_req(KIND_FLUSH, 16'hffff);
    settle();

    // Longest output period and widest count
    write_cfg(CFG_OUTPUT_COUNT, 24'hffffff);
    write_cfg(CFG_EXPORT_PERIOD, 24'h0fffff);
    push_req(KIND_SAMPLE, 16'h7fff);
    push_req(KIND_SAMPLE, 16'h8000);

    // Random phases under each idling pattern
    for (int r = 0; r < 3; r++) begin
      for (int s = 0; s < 2; s++) begin
        settle();
        case (r)
          0: begin src_idle = 13; snk_idle = 62; end
          1: begin src_idle = 62; snk_idle = 13; end
          default: begin src_idle = 0; snk_idle = 0; end
        endcase
        if ($urandom_range(5) == 0)
          write_cfg(CFG_EXPORT_PERIOD, 24'($urandom_range(4095, 1000)));
        else
          write_cfg(CFG_EXPORT_PERIOD, 24'($urandom_range(45000, 4096)));
        if (s == 1 && r != 2)
          write_cfg(CFG_OUTPUT_COUNT, 24'(produced + $urandom_range(60, 10)));
        else
          write_cfg(CFG_OUTPUT_COUNT, 24'hffffff);
        for (int i = 0; i < ITEMS_PER_SET; i++) begin
          if ($urandom_range(99) < 8) push_req(KIND_FLUSH, 16'($urandom));
          else push_req(KIND_SAMPLE, pick_sample());
        end
      end
    end
    settle();
    errors += expected_samples.size();

    $display("Resampled %0d requests (%0d flushes) under three idling patterns;",
             reqs_taken, flush_reqs);
    $display("%0d results checked, %0d held, %0d withheld at the count, %0d clipped requests",
             results_checked, held_results, withheld, clipped_reqs);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/lir_pkg.sv
src/lir_div.sv
src/lir_dp.sv
src/lir_ctrl.sv
src/linear_interp_resampler.sv
tb/testbench.sv
